### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the character LCD nibble writer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`endif

### sv/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg
// Types, constants and the strobe decoder shared by the LCD nibble writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

    // Command codes of the request channel.
    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_INSTR = 2'd1;
    localparam logic [1:0] CMD_CHAR  = 2'd2;
    localparam logic [1:0] CMD_ROW   = 2'd3;

    // Job kinds held in the queue.
    localparam logic JOB_BYTE = 1'b0;
    localparam logic JOB_INIT = 1'b1;

    // Register select levels.
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // Fixed instruction bytes.
    localparam logic [7:0] INSTR_SET_8BIT = 8'h30;
    localparam logic [7:0] INSTR_SET_4BIT = 8'h20;
    localparam logic [7:0] INSTR_CLEAR    = 8'h01;
    localparam logic [7:0] INSTR_ROW1     = 8'h80;
    localparam logic [7:0] INSTR_ROW2     = 8'hC0;

    localparam logic [7:0] ROW_ONE = 8'd1;
    localparam logic [7:0] ROW_TWO = 8'd2;

    // Wait times in milliseconds.
    localparam logic [5:0] POWER_ON_WAIT_MS = 6'd40;
    localparam logic [2:0] WAIT_AFTER_SET   = 3'd5;
    localparam logic [2:0] WAIT_AFTER_CLEAR = 3'd2;

    // Init sequence layout: nine bytes, eighteen strobes.
    localparam logic [3:0] IDX_SET_LAST  = 4'd2;
    localparam logic [3:0] IDX_CLEAR     = 4'd7;
    localparam logic [4:0] INIT_LAST_STEP = 5'd17;

    // Configuration reset values.
    localparam logic [7:0] RST_FUNC_SET  = 8'h28;
    localparam logic [7:0] RST_DISP_CTRL = 8'h0E;
    localparam logic [7:0] RST_ENTRY     = 8'h06;
    localparam logic [3:0] RST_MAX_CHARS = 4'd8;

    localparam int DEF_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] func_set;
        logic [7:0] disp_ctrl;
        logic [7:0] entry_mode;
        logic [3:0] max_chars;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic       rs;
        logic [7:0] data;
    } t_job;

    typedef struct packed {
        logic [3:0] nibble;
        logic       rs;
        logic [5:0] wait_before;
        logic [2:0] wait_after;
        logic       last;
    } t_strobe;

    // Byte sent at position idx of the init sequence.
    function automatic logic [7:0] init_byte(input logic [3:0] idx, input t_cfg cfg);
        logic [7:0] b;
        unique case (idx) inside
            4'd0, 4'd1, 4'd2: b = INSTR_SET_8BIT;
            4'd3:             b = INSTR_SET_4BIT;
            4'd4, 4'd5:       b = cfg.func_set;
            4'd6:             b = cfg.disp_ctrl;
            4'd7:             b = INSTR_CLEAR;
            4'd8:             b = cfg.entry_mode;
            default:          b = 8'h00;
        endcase
        return b;
    endfunction

    // Strobe number step of a job.
    function automatic t_strobe make_strobe(input t_job job, input logic [4:0] step,
                                            input t_cfg cfg);
        t_strobe    s;
        logic [7:0] b;
        logic [3:0] idx;
        idx           = step[4:1];
        s.wait_before = '0;
        s.wait_after  = '0;
        if (job.kind == JOB_INIT) begin
            b    = init_byte(idx, cfg);
            s.rs = RS_INSTR;
            if (step == 5'd0) begin
                s.wait_before = POWER_ON_WAIT_MS;
            end
            if (step[0] && (idx <= IDX_SET_LAST)) begin
                s.wait_after = WAIT_AFTER_SET;
            end else if (step[0] && (idx == IDX_CLEAR)) begin
                s.wait_after = WAIT_AFTER_CLEAR;
            end
            s.last = (step == INIT_LAST_STEP);
        end else begin
            b      = job.data;
            s.rs   = job.rs;
            s.last = step[0];
        end
        s.nibble = step[0] ? b[3:0] : b[7:4];
        return s;
    endfunction

endpackage

### sv/clnw_front.sv
// ----------------------------------------------------------------------------
// clnw_front
// Accepts commands, tracks string state and queues byte or init jobs.
// ----------------------------------------------------------------------------
module clnw_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_cmd,
    input  logic [7:0]      i_value,
    input  logic            i_starts_string,
    input  clnw_pkg::t_cfg  i_cfg,
    input  logic            i_full,
    output logic            o_push,
    output clnw_pkg::t_job  o_job
);
    import clnw_pkg::*;

    logic [3:0] r_chars;
    logic       r_ended;
    logic [3:0] n_chars;
    logic       n_ended;
    logic [3:0] w_chars;
    logic       w_ended;
    logic       w_open;
    logic       w_want;
    logic       w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        // A new string restarts the count before the limit check.
        w_chars = i_starts_string ? 4'd0 : r_chars;
        w_ended = i_starts_string ? 1'b0 : r_ended;
        w_open  = !w_ended && (w_chars < i_cfg.max_chars);
        n_chars = r_chars;
        n_ended = r_ended;
        w_want  = 1'b0;
        o_job   = '{kind: JOB_BYTE, rs: RS_INSTR, data: i_value};
        unique case (i_cmd)
            CMD_INIT: begin
                w_want     = 1'b1;
                o_job.kind = JOB_INIT;
            end
            CMD_INSTR: begin
                w_want = 1'b1;
            end
            CMD_CHAR: begin
                o_job.rs = RS_DATA;
                n_chars  = w_chars;
                n_ended  = w_ended;
                if (w_open && (i_value == 8'h00)) begin
                    n_ended = 1'b1;
                end else if (w_open) begin
                    w_want  = 1'b1;
                    n_chars = w_chars + 4'd1;
                end
            end
            CMD_ROW: begin
                if (i_value == ROW_ONE) begin
                    w_want     = 1'b1;
                    o_job.data = INSTR_ROW1;
                end else if (i_value == ROW_TWO) begin
                    w_want     = 1'b1;
                    o_job.data = INSTR_ROW2;
                end
            end
            default: begin
                w_want = 1'b0;
            end
        endcase
        o_push = w_accept && w_want;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars <= 4'd0;
            r_ended <= 1'b0;
        end else if (w_accept) begin
            r_chars <= n_chars;
            r_ended <= n_ended;
        end
    end

endmodule

### sv/clnw_fifo.sv
// ----------------------------------------------------------------------------
// clnw_fifo
// Small register queue between the command front and the strobe back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clnw_fifo #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

### sv/clnw_back.sv
// ----------------------------------------------------------------------------
// clnw_back
// Steps through queued jobs and registers one nibble strobe per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clnw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clnw_pkg::t_cfg    i_cfg,
    input  clnw_pkg::t_job    i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output clnw_pkg::t_strobe o_strobe
);
    import clnw_pkg::*;

    logic           r_valid;
    logic           r_busy;
    t_job           r_job;
    logic [4:0]     r_step;
    t_strobe        r_strobe;
    logic [4:0]     n_step;
    logic           w_adv;
    logic           w_have;
    t_job           w_job;
    logic [4:0]     w_step;
    t_strobe        w_strobe;

    always_comb begin
        w_adv    = !r_valid || i_ready;
        w_have   = r_busy || !i_empty;
        // An idle back end starts the head job at once.
        w_job    = r_busy ? r_job : i_head;
        w_step   = r_busy ? r_step : 5'd0;
        w_strobe = make_strobe(w_job, w_step, i_cfg);
        n_step   = w_step + 5'd1;
        o_pop    = w_adv && !r_busy && !i_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
        end else if (w_adv) begin
            r_valid <= w_have;
            if (w_have) begin
                r_busy <= !w_strobe.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_have) begin
            r_strobe <= w_strobe;
            r_job    <= w_job;
            r_step   <= n_step;
        end
    end

    assign o_valid  = r_valid;
    assign o_strobe = r_strobe;

    `ASSERT_IMPLIES(a_step_in_range, i_clk, i_rst_n, r_busy, r_step <= INIT_LAST_STEP)
    `ASSERT_IMPLIES(a_byte_second_half, i_clk, i_rst_n,
        r_busy && (r_job.kind == JOB_BYTE), r_step == 5'd1)
    `ASSERT_NEXT(a_busy_shows_strobe, i_clk, i_rst_n, r_busy, r_valid)

endmodule

### sv/char_lcd_nibble_writer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// Character LCD command sequencer producing 4-bit bus nibble strobes.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the request channel (i_in_valid / o_in_ready) as
// cmd, value and starts_string. Strobes leave on the result channel
// (o_out_valid / i_out_ready), each with a nibble, register select, waits in
// milliseconds and a last flag on the final strobe of a request.
// An instruction byte, string character or cursor row yields two strobes, an
// init request yields eighteen, and dropped characters or invalid rows yield
// none. A request is taken into a queue of QUEUE_DEPTH entries on the edge it
// is accepted; the back end then pops it from the queue and registers its
// first strobe in its output register. The back end emits one strobe per
// cycle while the receiver is ready, walking each job with its strobe step
// counter, and takes the next queued job once the last strobe of the current
// one is registered. Requests keep being accepted
// until the queue is full. When the receiver stalls, the output register holds
// its strobe and the queue fills, after which o_in_ready drops.
// Reset (synchronous, active low) empties the queue and output register,
// clears the string state and loads the default configuration words.
// Configuration is an APB-style port with registers at byte offsets 0, 4, 8
// and 12; pready is always high.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer #(
    parameter int QUEUE_DEPTH = clnw_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_value,
    input  logic        i_starts_string,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_nibble,
    output logic        o_register_select,
    output logic [5:0]  o_wait_before_ms,
    output logic [2:0]  o_wait_after_ms,
    output logic        o_last,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import clnw_pkg::*;

    // Register indexes, taken from the word address.
    localparam logic [1:0] REG_FUNC_SET  = 2'd0;
    localparam logic [1:0] REG_DISP_CTRL = 2'd1;
    localparam logic [1:0] REG_ENTRY     = 2'd2;
    localparam logic [1:0] REG_MAX_CHARS = 2'd3;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_reg;
    logic       w_full;
    logic       w_empty;
    logic       w_push;
    logic       w_pop;
    t_job       w_job_in;
    t_job       w_head;
    t_strobe    w_strobe;

    // Register file. Writes land on the access phase of an APB write.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.func_set   <= RST_FUNC_SET;
            r_cfg.disp_ctrl  <= RST_DISP_CTRL;
            r_cfg.entry_mode <= RST_ENTRY;
            r_cfg.max_chars  <= RST_MAX_CHARS;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_FUNC_SET:  r_cfg.func_set   <= pwdata[7:0];
                REG_DISP_CTRL: r_cfg.disp_ctrl  <= pwdata[7:0];
                REG_ENTRY:     r_cfg.entry_mode <= pwdata[7:0];
                REG_MAX_CHARS: r_cfg.max_chars  <= pwdata[3:0];
                default:       r_cfg            <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_FUNC_SET:  prdata = {24'd0, r_cfg.func_set};
            REG_DISP_CTRL: prdata = {24'd0, r_cfg.disp_ctrl};
            REG_ENTRY:     prdata = {24'd0, r_cfg.entry_mode};
            REG_MAX_CHARS: prdata = {28'd0, r_cfg.max_chars};
            default:       prdata = 32'd0;
        endcase
    end

    // The front end classifies each request and updates the string state;
    // only requests that produce strobes enter the queue.
    clnw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_cmd           (i_cmd),
        .i_value         (i_value),
        .i_starts_string (i_starts_string),
        .i_cfg           (r_cfg),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_job           (w_job_in)
    );

    clnw_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // The back end walks each job one strobe per cycle, while the receiver is
    // ready, into its output register; a stall blocks the front once the queue fills.
    clnw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (w_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_strobe (w_strobe)
    );

    assign o_nibble          = w_strobe.nibble;
    assign o_register_select = w_strobe.rs;
    assign o_wait_before_ms  = w_strobe.wait_before;
    assign o_wait_after_ms   = w_strobe.wait_after;
    assign o_last            = w_strobe.last;

endmodule

### tb/tb_char_lcd_nibble_writer.sv
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_writer
// Self-checking bench for the LCD nibble writer. Command requests flow from a
// queue into a valid/ready driver. A local model of the sequencer predicts
// the nibble strobes of every accepted request. A monitor compares each
// strobe that leaves the block, field by field, with the oldest prediction.
// Directed requests cover the init sequence, cursor rows, string ends and
// limits. Random phases then mix well-formed strings with loose commands
// under several register settings. Random gaps and stalls are used on both
// channels.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_writer;

    import clnw_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 300000;
    // Cycles allowed after the last strobe for requests that yield nothing.
    localparam int SETTLE_CYCLES = 24;

    // Byte addresses of the configuration registers.
    localparam logic [3:0] ADDR_FUNC_SET  = 4'd0;
    localparam logic [3:0] ADDR_DISP_CTRL = 4'd4;
    localparam logic [3:0] ADDR_ENTRY     = 4'd8;
    localparam logic [3:0] ADDR_MAX_CHARS = 4'd12;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] value;
        logic       starts;
    } t_lcd_request;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        in_valid     = 1'b0;
    logic [1:0]  in_cmd       = CMD_INSTR;
    logic [7:0]  in_value     = 8'h00;
    logic        in_starts    = 1'b0;
    logic        out_ready    = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = 4'd0;
    logic [31:0] pwdata  = 32'd0;

    logic        in_ready;
    logic        out_valid;
    logic [3:0]  out_nibble;
    logic        out_rs;
    logic [5:0]  out_wait_before;
    logic [2:0]  out_wait_after;
    logic        out_last;
    logic [31:0] prdata;
    logic        pready;

    // Requests waiting for the driver and strobes waiting for the monitor.
    t_lcd_request pending_requests[$];
    t_strobe      expected_strobes[$];

    // Shadow of the configuration registers and of the string state.
    logic [7:0]  shadow_func_set   = RST_FUNC_SET;
    logic [7:0]  shadow_disp_ctrl  = RST_DISP_CTRL;
    logic [7:0]  shadow_entry_mode = RST_ENTRY;
    logic [3:0]  shadow_max_chars  = RST_MAX_CHARS;
    logic [3:0]  string_chars_sent = 4'd0;
    logic        string_terminated = 1'b0;

    // Switches for random idling; some phases run with one or both off.
    logic        request_gaps_on = 1'b1;
    logic        strobe_stalls_on = 1'b1;

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          request_gap    = 0;
    int          strobe_stall   = 0;
    t_lcd_request driven_request;

    char_lcd_nibble_writer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_cmd             (in_cmd),
        .i_value           (in_value),
        .i_starts_string   (in_starts),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_nibble          (out_nibble),
        .o_register_select (out_rs),
        .o_wait_before_ms  (out_wait_before),
        .o_wait_after_ms   (out_wait_after),
        .o_last            (out_last),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Strobe prediction
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // A byte always leaves as two strobes, high nibble first. The wait before
    // rides on the first strobe and the wait after on the second.
    function automatic void expect_byte(input logic [7:0] data, input logic rs,
                                        input logic [5:0] wait_before,
                                        input logic [2:0] wait_after,
                                        input logic ends_request);
        t_strobe s;
        s.nibble      = data[7:4];
        s.rs          = rs;
        s.wait_before = wait_before;
        s.wait_after  = '0;
        s.last        = 1'b0;
        expected_strobes.push_back(s);
        s.nibble      = data[3:0];
        s.wait_before = '0;
        s.wait_after  = wait_after;
        s.last        = ends_request;
        expected_strobes.push_back(s);
    endfunction

    function automatic void predict_strobes(input t_lcd_request req);
        case (req.cmd)
            CMD_INIT: begin
                // Power-on wait, three 8-bit function sets, switch to 4-bit,
                // then the configured words with clear in the middle.
                expect_byte(INSTR_SET_8BIT, RS_INSTR, POWER_ON_WAIT_MS, WAIT_AFTER_SET, 1'b0);
                expect_byte(INSTR_SET_8BIT, RS_INSTR, '0, WAIT_AFTER_SET, 1'b0);
                expect_byte(INSTR_SET_8BIT, RS_INSTR, '0, WAIT_AFTER_SET, 1'b0);
                expect_byte(INSTR_SET_4BIT, RS_INSTR, '0, '0, 1'b0);
                expect_byte(shadow_func_set, RS_INSTR, '0, '0, 1'b0);
                expect_byte(shadow_func_set, RS_INSTR, '0, '0, 1'b0);
                expect_byte(shadow_disp_ctrl, RS_INSTR, '0, '0, 1'b0);
                expect_byte(INSTR_CLEAR, RS_INSTR, '0, WAIT_AFTER_CLEAR, 1'b0);
                expect_byte(shadow_entry_mode, RS_INSTR, '0, '0, 1'b1);
            end
            CMD_INSTR: begin
                expect_byte(req.value, RS_INSTR, '0, '0, 1'b1);
            end
            CMD_CHAR: begin
                if (req.starts) begin
                    string_chars_sent = 4'd0;
                    string_terminated = 1'b0;
                end
                // Characters past a NUL or past the limit are dropped silently.
                if (!string_terminated && string_chars_sent < shadow_max_chars) begin
                    if (req.value == 8'h00) begin
                        string_terminated = 1'b1;
                    end else begin
                        expect_byte(req.value, RS_DATA, '0, '0, 1'b1);
                        string_chars_sent = string_chars_sent + 4'd1;
                    end
                end
            end
            default: begin
                // Only rows one and two move the cursor; any other row is a no-op.
                if (req.value == ROW_ONE) begin
                    expect_byte(INSTR_ROW1, RS_INSTR, '0, '0, 1'b1);
                end else if (req.value == ROW_TWO) begin
                    expect_byte(INSTR_ROW2, RS_INSTR, '0, '0, 1'b1);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    // The prediction is made at the edge where the request is taken, so the
    // string state advances in the same order as inside the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid    <= 1'b0;
            request_gap = 0;
        end else begin
            if (in_valid && in_ready) begin
                predict_strobes(driven_request);
            end
            if (!in_valid || in_ready) begin
                if (request_gap > 0) begin
                    request_gap = request_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    driven_request = pending_requests.pop_front();
                    in_cmd      <= driven_request.cmd;
                    in_value    <= driven_request.value;
                    in_starts   <= driven_request.starts;
                    in_valid    <= 1'b1;
                    request_gap = request_gaps_on ? $urandom_range(0, 5) : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Strobe monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_strobe want;
        if (!i_rst_n) begin
            out_ready    <= 1'b0;
            strobe_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_strobes.size() == 0) begin
                    report_mismatch("strobe with nothing pending, nibble", out_nibble, 0);
                end else begin
                    want = expected_strobes.pop_front();
                    if (out_nibble != want.nibble)
                        report_mismatch("nibble", out_nibble, want.nibble);
                    if (out_rs != want.rs)
                        report_mismatch("register_select", out_rs, want.rs);
                    if (out_wait_before != want.wait_before)
                        report_mismatch("wait_before_ms", out_wait_before, want.wait_before);
                    if (out_wait_after != want.wait_after)
                        report_mismatch("wait_after_ms", out_wait_after, want.wait_after);
                    if (out_last != want.last)
                        report_mismatch("last", out_last, want.last);
                end
                strobe_stall = strobe_stalls_on ? $urandom_range(0, 5) : 0;
            end
            if (strobe_stall > 0) begin
                strobe_stall = strobe_stall - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration access and stimulus helpers
    // ------------------------------------------------------------------------

    // Writes one register, updates the shadow copy, then reads it back.
    task automatic write_register(input logic [3:0] addr, input logic [7:0] value);
        logic [31:0] readback;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (addr)
            ADDR_FUNC_SET:  shadow_func_set   = value;
            ADDR_DISP_CTRL: shadow_disp_ctrl  = value;
            ADDR_ENTRY:     shadow_entry_mode = value;
            default:        shadow_max_chars  = value[3:0];
        endcase
        readback = (addr == ADDR_MAX_CHARS) ? {28'd0, value[3:0]} : {24'd0, value};
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata != readback)
            report_mismatch("register readback", prdata, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_all_registers(input logic [7:0] func_set, input logic [7:0] disp_ctrl,
                                       input logic [7:0] entry_mode,
                                       input logic [3:0] max_chars);
        write_register(ADDR_FUNC_SET, func_set);
        write_register(ADDR_DISP_CTRL, disp_ctrl);
        write_register(ADDR_ENTRY, entry_mode);
        write_register(ADDR_MAX_CHARS, {4'd0, max_chars});
    endtask

    function automatic void push_request(input logic [1:0] cmd, input logic [7:0] value,
                                         input logic starts);
        t_lcd_request req;
        req.cmd    = cmd;
        req.value  = value;
        req.starts = starts;
        pending_requests.push_back(req);
    endfunction

    // Sampled on the falling edge so that the driver's updates have settled.
    // The extra cycles let dropped requests leave the block before a write.
    task automatic wait_for_drain();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || in_valid || expected_strobes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly whole strings with random content, sometimes broken by a missing
    // start flag or a stray one; the rest are loose commands.
    task automatic queue_random_requests(input int count);
        int queued;
        int pick;
        int length;
        logic [7:0] code;
        queued = 0;
        while (queued < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                length = $urandom_range(1, int'(shadow_max_chars) + 3);
                for (int k = 0; k < length; k++) begin
                    code = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
                    push_request(CMD_CHAR, code,
                                 (k == 0) ? ($urandom_range(0, 9) != 0)
                                          : ($urandom_range(0, 19) == 0));
                end
                queued += length;
            end else if (pick < 80) begin
                push_request(CMD_INSTR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                queued++;
            end else if (pick < 94) begin
                code = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 2))
                                                   : 8'($urandom_range(0, 255));
                push_request(CMD_ROW, code, 1'($urandom_range(0, 1)));
                queued++;
            end else begin
                push_request(CMD_INIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                queued++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: init, byte extremes, every cursor row kind,
        // a stray start flag on other commands, and a string cut by a NUL.
        push_request(CMD_INIT, 8'h00, 1'b0);
        push_request(CMD_INSTR, 8'h00, 1'b0);
        push_request(CMD_INSTR, 8'hFF, 1'b1);
        push_request(CMD_ROW, ROW_ONE, 1'b0);
        push_request(CMD_ROW, ROW_TWO, 1'b1);
        push_request(CMD_ROW, 8'd0, 1'b0);
        push_request(CMD_ROW, 8'd3, 1'b0);
        push_request(CMD_ROW, 8'hFF, 1'b0);
        push_request(CMD_CHAR, 8'h48, 1'b1);
        push_request(CMD_INIT, 8'hFF, 1'b1);
        push_request(CMD_CHAR, 8'hFF, 1'b0);
        push_request(CMD_CHAR, 8'h00, 1'b0);
        push_request(CMD_CHAR, 8'h41, 1'b0);
        push_request(CMD_CHAR, 8'h01, 1'b1);
        wait_for_drain();

        // A limit of one character: the second character and a late NUL are
        // dropped, and a string that opens with NUL sends nothing.
        write_all_registers(8'hFF, 8'h00, 8'hFF, 4'd1);
        push_request(CMD_INIT, 8'h00, 1'b0);
        push_request(CMD_CHAR, 8'h55, 1'b1);
        push_request(CMD_CHAR, 8'h66, 1'b0);
        push_request(CMD_CHAR, 8'h00, 1'b0);
        push_request(CMD_CHAR, 8'h00, 1'b1);
        push_request(CMD_CHAR, 8'h77, 1'b0);
        wait_for_drain();

        // A limit of zero drops every character, even at a string start.
        write_all_registers(8'h00, 8'hFF, 8'h00, 4'd0);
        push_request(CMD_INIT, 8'h00, 1'b0);
        push_request(CMD_CHAR, 8'h7F, 1'b1);
        push_request(CMD_INSTR, 8'hA5, 1'b0);
        wait_for_drain();

        // Random phases under varied settings; phase 0 uses the largest limit
        // and phase 1 the smallest. Phases 2 to 4 turn idling off on one or
        // both channels.
        for (int phase = 0; phase < 6; phase++) begin
            write_all_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)),
                                (phase == 0) ? 4'd15 :
                                (phase == 1) ? 4'd1 : 4'($urandom_range(1, 15)));
            request_gaps_on  = !(phase == 2 || phase == 4);
            strobe_stalls_on = !(phase == 2 || phase == 3);
            queue_random_requests(15);
            wait_for_drain();
        end

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
